### hw/rtl/vcrm_pkg.sv
// Shared types, constants and lane state encoding for the voxel column ray marcher.
`default_nettype none
package vcrm_pkg;

  localparam int DEPTH_STEPS_DEF = 128;
  localparam int RAY_COLUMNS_DEF = 128;
  localparam int RAY_ROWS_DEF    = 128;
  localparam int NUM_LANES       = 3;

  localparam logic [2:0] MODE_CAST1  = 3'd0;
  localparam logic [2:0] MODE_CAST2  = 3'd1;
  localparam logic [2:0] MODE_CAST3  = 3'd2;
  localparam logic [2:0] MODE_LD_MAP = 3'd3;
  localparam logic [2:0] MODE_LD_RX  = 3'd4;
  localparam logic [2:0] MODE_LD_RY  = 3'd5;

  localparam logic [7:0] CFG_SKY_COLOR   = 8'd0;
  localparam logic [7:0] CFG_DEPTH_SHIFT = 8'd1;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MOD,
    L_TAB,
    L_MAP,
    L_CMP
  } lane_state_t;

  typedef enum logic [0:0] {
    T_IDLE,
    T_RUN
  } top_state_t;

  // Cast request handed to one lane.
  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] eye;
    logic [7:0] start;
    logic [7:0] limit;
    logic [2:0] shift;
  } lane_cmd_t;

  // Table write broadcast to every lane.
  typedef struct packed {
    logic        map_we;
    logic        rx_we;
    logic        ry_we;
    logic [15:0] idx;
    logic [15:0] val;
  } lane_wr_t;

  // What a lane found.
  typedef struct packed {
    logic       done;
    logic       hit;
    logic [7:0] colour;
    logic [7:0] depth;
  } lane_res_t;

endpackage
`default_nettype wire

### hw/rtl/voxel_column_ray_march_core.sv
// Top level of the voxel column ray marcher: command decode, three lanes, merge, result register.
//
// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------------------
// in_      | start & !busy             | in_mode .. in_table_value
// out_     | out_valid, one cycle      | out_pixel_word_a/b, out_depth_out_a/b/c,
//          |                           | out_final_depth
// cfg_     | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// Loads (modes 3..5) are written at the accepting edge and keep busy low.
// A cast runs its columns in parallel lanes; each lane first reduces column
// and row modulo the table sizes (one subtract per cycle), then marches its
// depth steps, each a table read, a map read and a compare, in that order.
// A column takes at most DEPTH_STEPS depth steps.
// Synchronous active-low reset clears control state only; table contents
// stay undefined until loaded. The receiver cannot stall: out_valid pulses once.
`default_nettype none
module voxel_column_ray_march_core #(
  parameter int DEPTH_STEPS = vcrm_pkg::DEPTH_STEPS_DEF,
  parameter int RAY_COLUMNS = vcrm_pkg::RAY_COLUMNS_DEF,
  parameter int RAY_ROWS    = vcrm_pkg::RAY_ROWS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire   [2:0] in_mode,
  input  wire   [6:0] in_column,
  input  wire   [6:0] in_row,
  input  wire   [7:0] in_pos_x,
  input  wire   [7:0] in_pos_y,
  input  wire   [7:0] in_eye_height,
  input  wire   [7:0] in_start_depth_a,
  input  wire   [7:0] in_start_depth_b,
  input  wire   [7:0] in_start_depth_c,
  input  wire   [7:0] in_max_depth,
  input  wire  [15:0] in_table_index,
  input  wire  signed [15:0] in_table_value,
  output logic        out_valid,
  output logic [15:0] out_pixel_word_a,
  output logic [15:0] out_pixel_word_b,
  output logic  [7:0] out_depth_out_a,
  output logic  [7:0] out_depth_out_b,
  output logic  [7:0] out_depth_out_c,
  output logic  [7:0] out_final_depth,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire   [7:0] cfg_index,
  input  wire   [7:0] cfg_data
);
  import vcrm_pkg::*;

  top_state_t state_r, state_nxt;
  logic [7:0] sky_r;
  logic [2:0] shift_r;
  logic [2:0] mode_r;
  logic [7:0] eye_r;
  logic [6:0] row_r;
  logic [7:0] start_a_r, start_b_r, start_c_r;

  logic       accept, is_cast, all_done;
  logic [2:0] go;
  logic [7:0] limit;
  logic [7:0] off0, off1, off2;
  lane_cmd_t  cmd [NUM_LANES];
  lane_res_t  res [NUM_LANES];
  lane_wr_t   wr;

  logic [15:0] word_a, word_b;
  logic [7:0]  dout_a, dout_b, dout_c, final_d;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_cast   = (in_mode == MODE_CAST1) || (in_mode == MODE_CAST2) ||
                     (in_mode == MODE_CAST3);
  assign limit     = (int'(in_max_depth) < DEPTH_STEPS) ? in_max_depth : 8'(DEPTH_STEPS);
  assign all_done  = res[0].done && res[1].done && res[2].done;

  // Column offsets per cast mode.
  always_comb begin
    off0 = 8'd0;
    off1 = 8'd2;
    off2 = 8'd4;
    unique case (in_mode)
      MODE_CAST1: off0 = 8'd2;
      MODE_CAST2: begin
        off0 = 8'd1;
        off1 = 8'd4;
      end
      default: ;
    endcase
  end

  // Launch only the lanes this cast uses.
  always_comb begin
    go = 3'b000;
    if (accept) begin
      unique case (in_mode)
        MODE_CAST1: go = 3'b001;
        MODE_CAST2: go = 3'b011;
        MODE_CAST3: go = 3'b111;
        default:    go = 3'b000;
      endcase
    end
  end

  always_comb begin
    cmd[0] = '{col: {1'b0, in_column} + off0, row: in_row, pos_x: in_pos_x,
               pos_y: in_pos_y, eye: in_eye_height, start: in_start_depth_a,
               limit: limit, shift: shift_r};
    cmd[1] = cmd[0];
    cmd[1].col   = {1'b0, in_column} + off1;
    cmd[1].start = in_start_depth_b;
    cmd[2] = cmd[0];
    cmd[2].col   = {1'b0, in_column} + off2;
    cmd[2].start = in_start_depth_c;
  end

  // Broadcast table loads to every lane copy.
  always_comb begin
    wr.map_we = accept && (in_mode == MODE_LD_MAP);
    wr.rx_we  = accept && (in_mode == MODE_LD_RX);
    wr.ry_we  = accept && (in_mode == MODE_LD_RY);
    wr.idx    = in_table_index;
    wr.val    = in_table_value;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vcrm_lane #(
      .DEPTH_STEPS(DEPTH_STEPS),
      .RAY_COLUMNS(RAY_COLUMNS),
      .RAY_ROWS   (RAY_ROWS)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .go   (go[g]),
      .cmd  (cmd[g]),
      .wr   (wr),
      .res  (res[g])
    );
  end

  vcrm_merge u_merge (
    .mode     (mode_r),
    .sky_color(sky_r),
    .eye      (eye_r),
    .row      (row_r),
    .start_a  (start_a_r),
    .start_b  (start_b_r),
    .start_c  (start_c_r),
    .res_a    (res[0]),
    .res_b    (res[1]),
    .res_c    (res[2]),
    .word_a   (word_a),
    .word_b   (word_b),
    .dout_a   (dout_a),
    .dout_b   (dout_b),
    .dout_c   (dout_c),
    .final_d  (final_d)
  );

  // Next state: a cast runs until every lane is back to idle.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (accept && is_cast) state_nxt = T_RUN;
      T_RUN:  if (all_done) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != T_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= T_IDLE;
      out_valid <= 1'b0;
      sky_r     <= 8'd0;
      shift_r   <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == T_RUN) && all_done;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SKY_COLOR)   sky_r   <= cfg_data;
        if (cfg_index == CFG_DEPTH_SHIFT) shift_r <= cfg_data[2:0];
      end
    end
  end

  // Hold the cast context for the merge; register the result words.
  always_ff @(posedge clk) begin
    if (accept && is_cast) begin
      mode_r    <= in_mode;
      eye_r     <= in_eye_height;
      row_r     <= in_row;
      start_a_r <= in_start_depth_a;
      start_b_r <= in_start_depth_b;
      start_c_r <= in_start_depth_c;
    end
    if ((state_r == T_RUN) && all_done) begin
      out_pixel_word_a <= word_a;
      out_pixel_word_b <= word_b;
      out_depth_out_a  <= dout_a;
      out_depth_out_b  <= dout_b;
      out_depth_out_c  <= dout_c;
      out_final_depth  <= final_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/vcrm_lane.sv
// One marching lane: private copies of the map and ray tables, one depth step at a time.
`default_nettype none
module vcrm_lane #(
  parameter int DEPTH_STEPS = vcrm_pkg::DEPTH_STEPS_DEF,
  parameter int RAY_COLUMNS = vcrm_pkg::RAY_COLUMNS_DEF,
  parameter int RAY_ROWS    = vcrm_pkg::RAY_ROWS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 go,
  input  vcrm_pkg::lane_cmd_t cmd,
  input  vcrm_pkg::lane_wr_t  wr,
  output vcrm_pkg::lane_res_t res
);
  import vcrm_pkg::*;

  localparam int RX_ENTRIES = RAY_COLUMNS * DEPTH_STEPS;
  localparam int RY_ENTRIES = RAY_ROWS * DEPTH_STEPS;
  localparam int RXW = $clog2(RX_ENTRIES);
  localparam int RYW = $clog2(RY_ENTRIES);

  logic [15:0] map_mem [65536];
  logic [15:0] rx_mem  [RX_ENTRIES];
  logic [15:0] ry_mem  [RY_ENTRIES];

  lane_state_t state_r, state_nxt;
  lane_cmd_t   cmd_r;
  logic [7:0]  col_r, row_r, d_r;
  logic        hit_r;
  logic [7:0]  colour_r;
  logic [15:0] rx_q, ry_q, map_q;

  logic [RXW-1:0] rx_addr;
  logic [RYW-1:0] ry_addr;
  logic [15:0]    map_addr;
  logic [7:0]     mx, my;
  logic           col_big, row_big, is_hit, more;
  logic signed [17:0] lhs, rhs;

  assign col_big  = {1'b0, col_r} >= 9'(RAY_COLUMNS);
  assign row_big  = {1'b0, row_r} >= 9'(RAY_ROWS);
  assign rx_addr  = RXW'(int'(col_r) * DEPTH_STEPS + int'(d_r));
  assign ry_addr  = RYW'(int'(row_r) * DEPTH_STEPS + int'(d_r));
  assign mx       = cmd_r.pos_x + rx_q[7:0];
  assign my       = cmd_r.pos_y + 8'(16'(d_r) << cmd_r.shift);
  assign map_addr = {mx, my};
  assign lhs      = $signed({10'b0, map_q[7:0]});
  assign rhs      = $signed({10'b0, cmd_r.eye}) + $signed({{2{ry_q[15]}}, ry_q});
  assign is_hit   = lhs > rhs;
  assign more     = (d_r + 8'd1) < cmd_r.limit;

  // Table memories: broadcast writes, registered reads.
  always_ff @(posedge clk) begin
    if (wr.map_we) map_mem[wr.idx] <= wr.val;
    if (wr.rx_we && (int'(wr.idx) < RX_ENTRIES)) rx_mem[wr.idx[RXW-1:0]] <= wr.val;
    if (wr.ry_we && (int'(wr.idx) < RY_ENTRIES)) ry_mem[wr.idx[RYW-1:0]] <= wr.val;
    rx_q  <= rx_mem[rx_addr];
    ry_q  <= ry_mem[ry_addr];
    map_q <= map_mem[map_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (go) state_nxt = L_MOD;
      L_MOD:  if (!col_big && !row_big) state_nxt = (d_r < cmd_r.limit) ? L_TAB : L_IDLE;
      L_TAB:  state_nxt = L_MAP;
      L_MAP:  state_nxt = L_CMP;
      L_CMP:  state_nxt = (is_hit || !more) ? L_IDLE : L_TAB;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    res.done   = (state_r == L_IDLE);
    res.hit    = hit_r;
    res.colour = colour_r;
    res.depth  = d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      L_IDLE: if (go) begin
        cmd_r <= cmd;
        col_r <= cmd.col;
        row_r <= {1'b0, cmd.row};
        d_r   <= cmd.start;
        hit_r <= 1'b0;
      end
      L_MOD: begin
        // reduce column and row modulo the table sizes
        if (col_big) col_r <= 8'({1'b0, col_r} - 9'(RAY_COLUMNS));
        if (row_big) row_r <= 8'({1'b0, row_r} - 9'(RAY_ROWS));
      end
      L_CMP: begin
        if (is_hit) begin
          hit_r    <= 1'b1;
          colour_r <= map_q[15:8];
        end else begin
          d_r <= d_r + 8'd1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/vcrm_merge.sv
// Merge stage: sky shading, per-column colour choice and packing of the pixel words.
`default_nettype none
module vcrm_merge (
  input  wire                   [2:0] mode,
  input  wire                   [7:0] sky_color,
  input  wire                   [7:0] eye,
  input  wire                   [6:0] row,
  input  wire                   [7:0] start_a,
  input  wire                   [7:0] start_b,
  input  wire                   [7:0] start_c,
  input  vcrm_pkg::lane_res_t         res_a,
  input  vcrm_pkg::lane_res_t         res_b,
  input  vcrm_pkg::lane_res_t         res_c,
  output logic                 [15:0] word_a,
  output logic                 [15:0] word_b,
  output logic                  [7:0] dout_a,
  output logic                  [7:0] dout_b,
  output logic                  [7:0] dout_c,
  output logic                  [7:0] final_d
);
  import vcrm_pkg::*;

  logic [7:0] sky, c0, c1, c2;

  function automatic logic [15:0] pack(input logic [7:0] hi, input logic [7:0] mid,
                                       input logic [7:0] lo);
    pack = (16'(hi) << 10) + (16'(mid) << 5) + 16'(lo);
  endfunction

  always_comb begin
    sky = sky_color - {5'b0, eye[7:5]} - {4'b0, row[6:3]};
    c0  = res_a.hit ? res_a.colour : sky;
    c1  = res_b.hit ? res_b.colour : sky;
    c2  = res_c.hit ? res_c.colour : sky;
    dout_a = start_a;
    dout_b = start_b;
    dout_c = start_c;
    unique case (mode)
      MODE_CAST1: begin
        word_a  = pack(c0, c0, c0);
        word_b  = word_a;
        final_d = res_a.depth;
        if (res_a.hit) dout_a = res_a.depth;
      end
      MODE_CAST2: begin
        word_a  = pack(c0, c0, c0);
        word_b  = pack(c1, c1, c1);
        final_d = res_b.depth;
        if (res_a.hit) dout_a = res_a.depth;
        if (res_b.hit) dout_b = res_b.depth;
      end
      default: begin
        word_a  = pack(c0, c0, c1);
        word_b  = pack(c1, c2, c2);
        final_d = res_c.depth;
        if (res_a.hit) dout_a = res_a.depth;
        if (res_b.hit) dout_b = res_b.depth;
        if (res_c.hit) dout_c = res_c.depth;
      end
    endcase
  end

endmodule
`default_nettype wire
